FILE: rtl/rlm_pkg.sv
package rlm_pkg;

    localparam int TIME_W    = 63;
    localparam int LIMIT_W   = 32;
    localparam int COUNT_W   = 5;
    localparam int INDEX_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROTOR_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NO_COMM_TMO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_TIME = 2'd2;

    localparam logic OP_REPORT  = 1'b0;
    localparam logic OP_PUBLISH = 1'b1;

    localparam logic [LIMIT_W-1:0] NO_COMM_TMO_RESET   = 32'd100_000_000;
    localparam logic [LIMIT_W-1:0] RECOVERY_TIME_RESET = 32'd500_000_000;

    typedef struct packed {
        logic               operation;
        logic [INDEX_W-1:0] rotor_index;
        logic               comm_failure;
        logic [TIME_W-1:0]  timestamp_ns;
    } rlm_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] rotor_index_res;
        logic               alive;
        logic               last_of_report;
    } rlm_out_t;

    typedef struct packed {
        logic              alive;
        logic [TIME_W-1:0] good_time;
        logic [TIME_W-1:0] fail_time;
    } rlm_entry_t;

    typedef struct packed {
        logic       wr;
        logic       changed;
        rlm_entry_t entry;
    } rlm_decision_t;

    localparam rlm_entry_t ENTRY_RESET = '{alive: 1'b1, good_time: '0, fail_time: '0};

endpackage

FILE: rtl/rlm_table.sv
module rlm_table
    import rlm_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output rlm_entry_t       rd_entry,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  rlm_entry_t       wr_entry
);

    rlm_entry_t             mem [DEPTH];
    rlm_entry_t             rd_data_reg;
    logic                   rd_valid_reg;
    logic [DEPTH-1:0]       valid_reg;
    logic [DEPTH-1:0]       valid_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // An entry never written since the last clear reads as alive with zero times.
    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : ENTRY_RESET;

endmodule

FILE: rtl/rlm_decide.sv
module rlm_decide
    import rlm_pkg::*;
(
    input  rlm_entry_t          entry,
    input  logic                comm_failure,
    input  logic [TIME_W-1:0]   now,
    input  logic [LIMIT_W-1:0]  no_comm_timeout_ns,
    input  logic [LIMIT_W-1:0]  recovery_time_ns,
    output rlm_decision_t       decision
);

    logic [TIME_W-1:0]  ref_time;
    logic [LIMIT_W-1:0] limit;
    logic [TIME_W:0]    diff;
    logic               over;

    // Only one of the two timestamps matters for any given rotor state.
    assign ref_time = entry.alive ? entry.good_time : entry.fail_time;
    assign limit    = entry.alive ? no_comm_timeout_ns : recovery_time_ns;
    assign diff     = {1'b0, now} - {1'b0, ref_time};
    // A borrow means time went backwards, which counts as no time elapsed.
    assign over     = !diff[TIME_W] && (diff[TIME_W-1:0] > TIME_W'(limit));

    always_comb
    begin
        decision.wr      = 1'b0;
        decision.changed = 1'b0;
        decision.entry   = entry;
        if (entry.alive)
        begin
            if (!comm_failure)
            begin
                decision.wr              = 1'b1;
                decision.entry.good_time = now;
            end
            else if (over)
            begin
                decision.wr              = 1'b1;
                decision.changed         = 1'b1;
                decision.entry.alive     = 1'b0;
                decision.entry.fail_time = now;
            end
        end
        else
        begin
            if (comm_failure)
            begin
                decision.wr              = 1'b1;
                decision.entry.fail_time = now;
            end
            else if (over)
            begin
                decision.wr              = 1'b1;
                decision.changed         = 1'b1;
                decision.entry.alive     = 1'b1;
                decision.entry.good_time = now;
            end
        end
    end

endmodule

FILE: rtl/rotor_liveness_monitor_unit.sv
// Status report: an in-range rotor's entry is read on acceptance, then updated in ST_UPDATE;
// in_ready stays low until the block returns to ST_IDLE.
// A publish beat loads its first result in ST_PUB_LD, a report that changes state goes through
// ST_UPDATE and ST_PUB_RD first; then one result per monitored rotor per cycle when out_ready stays high.
// Reset (rst_n, asynchronous) marks all rotors alive with zero times and sets rotor_count to 0;
// writing rotor_count clears the table the same way, in the same cycle.
module rotor_liveness_monitor_unit
    import rlm_pkg::*;
#(
    parameter int MAX_ROTORS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rlm_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rlm_out_t             out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]   cfg_data
);

    localparam int AW    = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1;
    localparam int CNT_W = $clog2(MAX_ROTORS + 1);
    localparam int CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_PUB_RD = 2'd2;
    localparam logic [1:0] ST_PUB_LD = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [COUNT_W-1:0]  rotor_count_reg;
    logic [LIMIT_W-1:0]  no_comm_tmo_reg;
    logic [LIMIT_W-1:0]  recovery_time_reg;
    logic [AW-1:0]       pub_idx_reg;
    logic [AW-1:0]       pub_idx_next;
    logic [AW-1:0]       upd_addr_reg;
    logic                upd_fail_reg;
    logic [TIME_W-1:0]   upd_time_reg;
    logic                out_valid_reg;
    rlm_out_t            out_data_reg;

    logic [CW-1:0]       count_ext;
    logic [CW-1:0]       max_ext;
    logic [CW-1:0]       active_count;
    logic [AW+INDEX_W-1:0] in_addr_wide;
    logic [AW-1:0]       in_addr;
    logic [AW+INDEX_W-1:0] pub_idx_wide;
    logic                in_range;
    logic                accept;
    logic                pub_last;
    logic                load;
    logic                clear;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    rlm_entry_t          rd_entry;
    rlm_decision_t       decision;

    assign count_ext    = CW'(rotor_count_reg);
    assign max_ext      = CW'(MAX_ROTORS);
    assign active_count = (count_ext > max_ext) ? max_ext : count_ext;

    assign in_addr_wide = {{AW{1'b0}}, in_data.rotor_index};
    assign in_addr      = in_addr_wide[AW-1:0];
    assign in_range     = CW'(in_data.rotor_index) < active_count;
    assign pub_idx_wide = {{INDEX_W{1'b0}}, pub_idx_reg};

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign pub_last = (CW'(pub_idx_reg) + CW'(1)) == active_count;
    assign load     = (state_reg == ST_PUB_LD) && (!out_valid_reg || out_ready);
    assign clear    = cfg_write && (cfg_index == REG_ROTOR_COUNT);

    always_comb
    begin
        state_next   = state_reg;
        pub_idx_next = pub_idx_reg;
        rd_en        = 1'b0;
        rd_addr      = pub_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                pub_idx_next = '0;
                if (in_data.operation == OP_PUBLISH)
                begin
                    rd_addr = '0;
                    if (accept && (active_count != '0))
                    begin
                        rd_en      = 1'b1;
                        state_next = ST_PUB_LD;
                    end
                end
                else
                begin
                    rd_addr = in_addr;
                    if (accept && in_range)
                    begin
                        rd_en      = 1'b1;
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE:
            begin
                // The publish read is issued from ST_PUB_RD so it sees the entry just written.
                pub_idx_next = '0;
                state_next   = decision.changed ? ST_PUB_RD : ST_IDLE;
            end
            ST_PUB_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_PUB_LD;
            end
            ST_PUB_LD:
            begin
                rd_addr = pub_idx_reg + AW'(1);
                if (load)
                begin
                    if (pub_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_en        = 1'b1;
                        pub_idx_next = pub_idx_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            pub_idx_reg       <= '0;
            out_valid_reg     <= 1'b0;
            rotor_count_reg   <= '0;
            no_comm_tmo_reg   <= NO_COMM_TMO_RESET;
            recovery_time_reg <= RECOVERY_TIME_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            pub_idx_reg <= pub_idx_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_ROTOR_COUNT:   rotor_count_reg   <= cfg_data[COUNT_W-1:0];
                    REG_NO_COMM_TMO:   no_comm_tmo_reg   <= cfg_data;
                    REG_RECOVERY_TIME: recovery_time_reg <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upd_addr_reg <= in_addr;
            upd_fail_reg <= in_data.comm_failure;
            upd_time_reg <= in_data.timestamp_ns;
        end
        if (load)
        begin
            out_data_reg.rotor_index_res <= pub_idx_wide[INDEX_W-1:0];
            out_data_reg.alive           <= rd_entry.alive;
            out_data_reg.last_of_report  <= pub_last;
        end
    end

    rlm_table #(
        .DEPTH (MAX_ROTORS),
        .AW    (AW)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (clear),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .wr_en    ((state_reg == ST_UPDATE) && decision.wr),
        .wr_addr  (upd_addr_reg),
        .wr_entry (decision.entry)
    );

    rlm_decide u_decide (
        .entry              (rd_entry),
        .comm_failure       (upd_fail_reg),
        .now                (upd_time_reg),
        .no_comm_timeout_ns (no_comm_tmo_reg),
        .recovery_time_ns   (recovery_time_reg),
        .decision           (decision)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
